// ----- hdl/wepc_pkg.sv -----
// shared constants, types and rounding helper for the edge projector
package wepc_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int SCREEN_SIZE  = 1024;
  localparam int DEPTH_OFFSET = (23 * (1 << FRAC_BITS) + 5) / 10;
  localparam int NEAR_DEPTH   = (1 << FRAC_BITS) / 4;
  localparam int FOCAL        = 84;

  localparam int COORD_W    = 10;
  localparam int WIDTH_W    = 11;
  localparam int DEPTH_W    = 19;
  localparam int DIVIDEND_W = 30;
  localparam int DEN_W      = 20;
  localparam int QUOT_W     = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

  typedef enum logic [2:0] {
    CFG_COS_YAW,
    CFG_SIN_YAW,
    CFG_COS_PITCH,
    CFG_SIN_PITCH,
    CFG_SCREEN_WIDTH,
    CFG_BAND_TOP,
    CFG_BAND_BOTTOM
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0]   cos_yaw;
    logic signed [15:0]   sin_yaw;
    logic signed [15:0]   cos_pitch;
    logic signed [15:0]   sin_pitch;
    logic [COORD_W-1:0]   cxp;
    logic [COORD_W-1:0]   cyp;
  } cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DEN_W-1:0]      den;
  } div_req_t;

  // shift right by FRAC_BITS, round half away from zero, saturate to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [33:0] v);
    logic [33:0]        mag;
    logic [33:0]        q;
    logic signed [34:0] sv;
    mag = v[33] ? 34'(-v) : 34'(v);
    q   = (mag + 34'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    sv  = v[33] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (sv > 35'sd32767) begin
      return 16'sh7fff;
    end else if (sv < -35'sd32768) begin
      return 16'sh8000;
    end else begin
      return sv[15:0];
    end
  endfunction

endpackage

// ----- hdl/wepc_rotate.sv -----
// rotation, depth and projection numerator pipeline for one endpoint
module wepc_rotate (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [15:0]        x_i,
  input  logic signed [15:0]        y_i,
  input  logic signed [15:0]        z_i,
  input  wepc_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output wepc_pkg::div_req_t        col_req_o,
  output wepc_pkg::div_req_t        row_req_o
);

  localparam int DEPTH_W_L = wepc_pkg::DEPTH_W;

  logic [5:0] vld_q;

  logic signed [31:0] p_xc_q, p_zs_q, p_zc_q, p_xs_q;
  logic signed [15:0] y1_q, y2_q;
  logic signed [15:0] xx2_q, zz2_q, xx3_q, xx4_q;
  logic signed [31:0] p_yc_q, p_zsp_q, p_ysp_q, p_zcp_q;
  logic signed [15:0] ry4_q, rz4_q;
  logic signed [DEPTH_W_L-1:0] d_raw;
  logic [DEPTH_W_L-1:0] d_d, d5_q;
  logic [wepc_pkg::COORD_W+DEPTH_W_L-1:0] pc5_q, pr5_q;
  logic signed [22:0] fx5_q, fy5_q;
  logic signed [30:0] ncol, nrow;
  logic [30:0] mcol, mrow;
  wepc_pkg::div_req_t col_d, row_d, col_q, row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // depth with offset, held at the near limit
  always_comb begin
    d_raw = DEPTH_W_L'(rz4_q) + DEPTH_W_L'(wepc_pkg::DEPTH_OFFSET);
    if (d_raw < $signed(DEPTH_W_L'(wepc_pkg::NEAR_DEPTH))) begin
      d_d = DEPTH_W_L'(wepc_pkg::NEAR_DEPTH);
    end else begin
      d_d = d_raw;
    end
  end

  always_comb begin
    ncol = $signed({2'b00, pc5_q}) + 31'(fx5_q);
    nrow = $signed({2'b00, pr5_q}) - 31'(fy5_q);
    mcol = ncol[30] ? 31'(-ncol) : 31'(ncol);
    mrow = nrow[30] ? 31'(-nrow) : 31'(nrow);
    col_d.neg      = ncol[30];
    col_d.dividend = wepc_pkg::DIVIDEND_W'({mcol, 1'b0} + 32'(d5_q));
    col_d.den      = wepc_pkg::DEN_W'({d5_q, 1'b0});
    row_d.neg      = nrow[30];
    row_d.dividend = wepc_pkg::DIVIDEND_W'({mrow, 1'b0} + 32'(d5_q));
    row_d.den      = wepc_pkg::DEN_W'({d5_q, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    p_xc_q  <= x_i * cfg_i.cos_yaw;
    p_zs_q  <= z_i * cfg_i.sin_yaw;
    p_zc_q  <= z_i * cfg_i.cos_yaw;
    p_xs_q  <= x_i * cfg_i.sin_yaw;
    y1_q    <= y_i;
    xx2_q   <= wepc_pkg::rnd_sat(34'(p_xc_q) + 34'(p_zs_q));
    zz2_q   <= wepc_pkg::rnd_sat(34'(p_zc_q) - 34'(p_xs_q));
    y2_q    <= y1_q;
    p_yc_q  <= y2_q * cfg_i.cos_pitch;
    p_zsp_q <= zz2_q * cfg_i.sin_pitch;
    p_ysp_q <= y2_q * cfg_i.sin_pitch;
    p_zcp_q <= zz2_q * cfg_i.cos_pitch;
    xx3_q   <= xx2_q;
    ry4_q   <= wepc_pkg::rnd_sat(34'(p_yc_q) - 34'(p_zsp_q));
    rz4_q   <= wepc_pkg::rnd_sat(34'(p_ysp_q) + 34'(p_zcp_q));
    xx4_q   <= xx3_q;
    d5_q    <= d_d;
    pc5_q   <= cfg_i.cxp * d_d;
    pr5_q   <= cfg_i.cyp * d_d;
    fx5_q   <= $signed(8'(wepc_pkg::FOCAL)) * xx4_q;
    fy5_q   <= $signed(8'(wepc_pkg::FOCAL)) * ry4_q;
    col_q   <= col_d;
    row_q   <= row_d;
  end

  assign valid_o   = vld_q[5];
  assign col_req_o = col_q;
  assign row_req_o = row_q;

endmodule

// ----- hdl/wepc_div.sv -----
// pipelined restoring divider, two quotient bits per stage, rounded signed result
module wepc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  wepc_pkg::div_req_t   req_i,
  output logic                 valid_o,
  output logic signed [15:0]   value_o
);

  localparam int NS = wepc_pkg::DIV_STAGES;
  localparam int RW = wepc_pkg::DIVIDEND_W;
  localparam int DW = wepc_pkg::DEN_W;
  localparam int QW = wepc_pkg::QUOT_W;
  localparam int WW = RW + QW;

  logic [RW-1:0] rem_q  [NS];
  logic [DW-1:0] den_q  [NS];
  logic [QW-1:0] quot_q [NS];
  logic          neg_q  [NS];
  logic [NS-1:0] vld_q;
  logic          out_vld_q;
  logic signed [15:0] value_q;
  logic signed [QW:0] sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NS-2:0], valid_i};
      out_vld_q <= vld_q[NS-1];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic          neg_in;
    logic [RW-1:0] rem_nx;
    logic [QW-1:0] quot_nx;

    if (k == 0) begin : g_first
      assign rem_in  = req_i.dividend;
      assign den_in  = req_i.den;
      assign quot_in = '0;
      assign neg_in  = req_i.neg;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign neg_in  = neg_q[k-1];
    end

    always_comb begin
      logic [WW-1:0] trial;
      rem_nx  = rem_in;
      quot_nx = quot_in;
      for (int j = 0; j < wepc_pkg::DIV_STEPS; j++) begin
        trial = WW'(den_in) << (QW - 1 - (k * wepc_pkg::DIV_STEPS + j));
        if (WW'(rem_nx) >= trial) begin
          rem_nx = RW'(WW'(rem_nx) - trial);
          quot_nx[QW - 1 - (k * wepc_pkg::DIV_STEPS + j)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_nx;
      den_q[k]  <= den_in;
      quot_q[k] <= quot_nx;
      neg_q[k]  <= neg_in;
    end
  end

  always_comb begin
    sq = neg_q[NS-1] ? -$signed({1'b0, quot_q[NS-1]}) : $signed({1'b0, quot_q[NS-1]});
  end

  always_ff @(posedge clk_i) begin
    if (sq > 17'sd32767) begin
      value_q <= 16'sh7fff;
    end else if (sq < -17'sd32768) begin
      value_q <= 16'sh8000;
    end else begin
      value_q <= sq[15:0];
    end
  end

  assign valid_o = out_vld_q;
  assign value_o = value_q;

endmodule

// ----- hdl/wireframe_edge_project_clip_unit.sv -----
// top level: config registers, two endpoint pipelines, four dividers, reject and clamp
// Projects one wireframe edge per clock: start may be held high every cycle and
// busy is never raised. Each edge passes through six rotate/project stages, the
// eight-stage divider (two quotient bits per stage), its output register and the
// clip register, and comes out on the cycle where valid_o is high; the result is
// there for that one cycle only, since the receiver cannot stall.
// Write configuration only while no edge is in flight.
module wireframe_edge_project_clip_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  first_x_i,
  input  logic signed [15:0]  first_y_i,
  input  logic signed [15:0]  first_z_i,
  input  logic signed [15:0]  second_x_i,
  input  logic signed [15:0]  second_y_i,
  input  logic signed [15:0]  second_z_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output logic                valid_o,
  output logic                visible_o,
  output logic [9:0]          start_col_o,
  output logic [9:0]          start_row_o,
  output logic [9:0]          end_col_o,
  output logic [9:0]          end_row_o
);

  localparam int CW = wepc_pkg::COORD_W;
  localparam int WW = wepc_pkg::WIDTH_W;

  logic signed [15:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic [WW-1:0] screen_width_q;
  logic [CW-1:0] band_top_q, band_bottom_q;
  logic [WW-1:0] w_eff;
  logic [CW:0]   band_sum;
  wepc_pkg::cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q      <= 16'sd16384;
      sin_yaw_q      <= '0;
      cos_pitch_q    <= 16'sd16384;
      sin_pitch_q    <= '0;
      screen_width_q <= WW'(wepc_pkg::SCREEN_SIZE);
      band_top_q     <= '0;
      band_bottom_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wepc_pkg::CFG_COS_YAW:      cos_yaw_q      <= cfg_data_i;
        wepc_pkg::CFG_SIN_YAW:      sin_yaw_q      <= cfg_data_i;
        wepc_pkg::CFG_COS_PITCH:    cos_pitch_q    <= cfg_data_i;
        wepc_pkg::CFG_SIN_PITCH:    sin_pitch_q    <= cfg_data_i;
        wepc_pkg::CFG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[WW-1:0];
        wepc_pkg::CFG_BAND_TOP:     band_top_q     <= cfg_data_i[CW-1:0];
        wepc_pkg::CFG_BAND_BOTTOM:  band_bottom_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (screen_width_q == '0) begin
      w_eff = WW'(1);
    end else if (screen_width_q > WW'(wepc_pkg::SCREEN_SIZE)) begin
      w_eff = WW'(wepc_pkg::SCREEN_SIZE);
    end else begin
      w_eff = screen_width_q;
    end
    band_sum      = {1'b0, band_top_q} + {1'b0, band_bottom_q};
    cfg.cos_yaw   = cos_yaw_q;
    cfg.sin_yaw   = sin_yaw_q;
    cfg.cos_pitch = cos_pitch_q;
    cfg.sin_pitch = sin_pitch_q;
    cfg.cxp       = CW'(w_eff >> 1);
    cfg.cyp       = band_sum[CW:1];
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic v_a, v_b;
  wepc_pkg::div_req_t col_a, row_a, col_b, row_b;

  wepc_rotate u_rot_first (
    .clk_i, .rst_ni, .valid_i(accept),
    .x_i(first_x_i), .y_i(first_y_i), .z_i(first_z_i), .cfg_i(cfg),
    .valid_o(v_a), .col_req_o(col_a), .row_req_o(row_a)
  );

  wepc_rotate u_rot_second (
    .clk_i, .rst_ni, .valid_i(accept),
    .x_i(second_x_i), .y_i(second_y_i), .z_i(second_z_i), .cfg_i(cfg),
    .valid_o(v_b), .col_req_o(col_b), .row_req_o(row_b)
  );

  logic vx0, vy0, vx1, vy1;
  logic signed [15:0] x0, y0, x1, y1;

  wepc_div u_div_x0 (.clk_i, .rst_ni, .valid_i(v_a), .req_i(col_a), .valid_o(vx0), .value_o(x0));
  wepc_div u_div_y0 (.clk_i, .rst_ni, .valid_i(v_a), .req_i(row_a), .valid_o(vy0), .value_o(y0));
  wepc_div u_div_x1 (.clk_i, .rst_ni, .valid_i(v_b), .req_i(col_b), .valid_o(vx1), .value_o(x1));
  wepc_div u_div_y1 (.clk_i, .rst_ni, .valid_i(v_b), .req_i(row_b), .valid_o(vy1), .value_o(y1));

  logic signed [16:0] ws, wm1, tops, bots;
  logic reject;
  logic [CW-1:0] cx0, cy0, cx1, cy1;

  function automatic logic [9:0] clamp_row(input logic signed [15:0] v,
                                           input logic signed [16:0] lo,
                                           input logic signed [16:0] hi);
    if (17'(v) < lo) begin
      return lo[9:0];
    end else if (17'(v) > hi) begin
      return hi[9:0];
    end else begin
      return v[9:0];
    end
  endfunction

  function automatic logic [9:0] clamp_col(input logic signed [15:0] v,
                                           input logic signed [16:0] hi);
    if (v < 16'sd0) begin
      return '0;
    end else if (17'(v) > hi) begin
      return hi[9:0];
    end else begin
      return v[9:0];
    end
  endfunction

  always_comb begin
    ws   = $signed({6'b0, w_eff});
    wm1  = ws - 17'sd1;
    tops = $signed({7'b0, band_top_q});
    bots = $signed({7'b0, band_bottom_q});
    reject = (x0 < 16'sd0 && x1 < 16'sd0) ||
             (17'(x0) >= ws && 17'(x1) >= ws) ||
             (17'(y0) < tops && 17'(y1) < tops) ||
             (17'(y0) > bots && 17'(y1) > bots);
    cx0 = clamp_col(x0, wm1);
    cx1 = clamp_col(x1, wm1);
    cy0 = clamp_row(y0, tops, bots);
    cy1 = clamp_row(y1, tops, bots);
  end

  logic       valid_q, visible_q;
  logic [9:0] start_col_q, start_row_q, end_col_q, end_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      visible_q <= 1'b0;
    end else begin
      valid_q   <= vx0;
      visible_q <= vx0 && !reject;
    end
  end

  always_ff @(posedge clk_i) begin
    start_col_q <= reject ? '0 : cx0;
    start_row_q <= reject ? '0 : cy0;
    end_col_q   <= reject ? '0 : cx1;
    end_row_q   <= reject ? '0 : cy1;
  end

  assign valid_o     = valid_q;
  assign visible_o   = visible_q;
  assign start_col_o = start_col_q;
  assign start_row_o = start_row_q;
  assign end_col_o   = end_col_q;
  assign end_row_o   = end_row_q;

`ifndef SYNTHESIS
  // the four divider lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx0 == vy0) && (vx0 == vx1) && (vx0 == vy1))
    else $error("divider lanes out of step");

  a_visible_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visible_o |-> valid_o)
    else $error("visible without a result beat");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !visible_o) |->
      (start_col_o == '0 && start_row_o == '0 && end_col_o == '0 && end_row_o == '0))
    else $error("rejected edge carries coordinates");
`endif

endmodule

// ----- tb/sv/wireframe_edge_project_clip_unit_tb.sv -----
// self-checking testbench for the wireframe edge projector with band clipping
`timescale 1ns / 1ps

module wireframe_edge_project_clip_unit_tb;

  localparam int LATENCY     = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       visible;
    logic [9:0] start_col;
    logic [9:0] start_row;
    logic [9:0] end_col;
    logic [9:0] end_row;
  } edge_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] first_x_i, first_y_i, first_z_i;
  logic signed [15:0] second_x_i, second_y_i, second_z_i;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               valid_o;
  logic               visible_o;
  logic [9:0]         start_col_o, start_row_o, end_col_o, end_row_o;

  wireframe_edge_project_clip_unit u_top (.*);

  // local copy of the register file
  logic signed [15:0] m_cos_yaw, m_sin_yaw, m_cos_pitch, m_sin_pitch;
  logic [10:0]        m_width;
  logic [9:0]         m_top, m_bot;

  edge_out_t pending_edges[$];
  int        n_errors;
  int        n_edges;
  int        n_visible;
  int        n_cfg;
  longint    cycle_cnt;
  bit        calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint frac_round(input longint v);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = (mag + (longint'(1) << (wepc_pkg::FRAC_BITS - 1))) >>> wepc_pkg::FRAC_BITS;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint div_away(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic void screen_point(input longint x, input longint y, input longint z,
                                       input longint cx, input longint cy,
                                       output longint col, output longint row);
    longint xx, zz, ry, rz, d;
    xx = sat16(frac_round(x * m_cos_yaw + z * m_sin_yaw));
    zz = sat16(frac_round(z * m_cos_yaw - x * m_sin_yaw));
    ry = sat16(frac_round(y * m_cos_pitch - zz * m_sin_pitch));
    rz = sat16(frac_round(y * m_sin_pitch + zz * m_cos_pitch));
    d  = rz + wepc_pkg::DEPTH_OFFSET;
    if (d < wepc_pkg::NEAR_DEPTH) d = wepc_pkg::NEAR_DEPTH;
    col = sat16(div_away(cx * d + wepc_pkg::FOCAL * xx, d));
    row = sat16(div_away(cy * d - wepc_pkg::FOCAL * ry, d));
  endfunction

  function automatic edge_out_t project_edge(input logic signed [15:0] ax, ay, az,
                                             input logic signed [15:0] bx, by, bz);
    edge_out_t r;
    longint w, top, bot, cx, cy, x0, y0, x1, y1;
    w   = m_width;
    top = m_top;
    bot = m_bot;
    if (w < 1) w = 1;
    if (w > wepc_pkg::SCREEN_SIZE) w = wepc_pkg::SCREEN_SIZE;
    cx = w / 2;
    cy = (top + bot) / 2;
    screen_point(ax, ay, az, cx, cy, x0, y0);
    screen_point(bx, by, bz, cx, cy, x1, y1);
    r = '0;
    if ((x0 < 0 && x1 < 0) || (x0 >= w && x1 >= w) ||
        (y0 < top && y1 < top) || (y0 > bot && y1 > bot)) begin
      return r;
    end
    x0 = (x0 < 0) ? 0 : ((x0 > w - 1) ? w - 1 : x0);
    x1 = (x1 < 0) ? 0 : ((x1 > w - 1) ? w - 1 : x1);
    y0 = (y0 < top) ? top : ((y0 > bot) ? bot : y0);
    y1 = (y1 < top) ? top : ((y1 > bot) ? bot : y1);
    r.visible   = 1'b1;
    r.start_col = x0[9:0];
    r.start_row = y0[9:0];
    r.end_col   = x1[9:0];
    r.end_row   = y1[9:0];
    return r;
  endfunction

  // result checker: one beat per valid cycle
  always @(posedge clk_i) begin
    edge_out_t want;
    if (rst_ni && valid_o) begin
      if (pending_edges.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = pending_edges.pop_front();
        if (visible_o !== want.visible) report("visible", visible_o, want.visible);
        if (start_col_o !== want.start_col) report("start_col", start_col_o, want.start_col);
        if (start_row_o !== want.start_row) report("start_row", start_row_o, want.start_row);
        if (end_col_o !== want.end_col) report("end_col", end_col_o, want.end_col);
        if (end_row_o !== want.end_row) report("end_row", end_row_o, want.end_row);
        if (want.visible) n_visible++;
      end
    end
  end

  // start stays high after a beat so edges can follow back to back
  task automatic send_edge(input logic signed [15:0] ax, ay, az, bx, by, bz);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start      <= 1'b1;
    first_x_i  <= ax;
    first_y_i  <= ay;
    first_z_i  <= az;
    second_x_i <= bx;
    second_y_i <= by;
    second_z_i <= bz;
    do @(posedge clk_i); while (busy);
    pending_edges.push_back(project_edge(ax, ay, az, bx, by, bz));
    n_edges++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input wepc_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    n_cfg++;
    case (idx)
      wepc_pkg::CFG_COS_YAW:      m_cos_yaw   = val;
      wepc_pkg::CFG_SIN_YAW:      m_sin_yaw   = val;
      wepc_pkg::CFG_COS_PITCH:    m_cos_pitch = val;
      wepc_pkg::CFG_SIN_PITCH:    m_sin_pitch = val;
      wepc_pkg::CFG_SCREEN_WIDTH: m_width     = val[10:0];
      wepc_pkg::CFG_BAND_TOP:     m_top       = val[9:0];
      wepc_pkg::CFG_BAND_BOTTOM:  m_bot       = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [15:0] cy, sy, cp, sp, w, top, bot);
    drain();
    write_reg(wepc_pkg::CFG_COS_YAW, cy);
    write_reg(wepc_pkg::CFG_SIN_YAW, sy);
    write_reg(wepc_pkg::CFG_COS_PITCH, cp);
    write_reg(wepc_pkg::CFG_SIN_PITCH, sp);
    write_reg(wepc_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(wepc_pkg::CFG_BAND_TOP, top);
    write_reg(wepc_pkg::CFG_BAND_BOTTOM, bot);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(16384);
      2: return 16'(-16384);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed;
    send_edge(0, 0, 0, 0, 0, 0);
    send_edge(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_edge(16'h8000, 0, 16'h8000, 16'h8000, 0, 16'h8000);  // both off left, smallest depth
    send_edge(16'h7fff, 0, 0, 16'h7000, 0, 0);                 // both right of centre
    send_edge(16'h8000, 0, 0, 16'h9000, 0, 0);                 // both left of centre
    send_edge(0, 16'h7fff, 0, 0, 16'h7000, 0);                 // both above centre
    send_edge(0, 16'h8000, 0, 0, 16'h9000, 0);                 // both below centre
    send_edge(16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 0);   // crossing the centre
    send_edge(16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
    set_view(16'(-16384), 16'(16384), 16'(-16384), 16'(16384), 0, 600, 200);
    send_edge(0, 0, 0, 1000, -1000, 2000);                     // zero width, inverted band
    send_edge(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    set_view(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 11'h7ff, 1023, 1023);
    send_edge(4000, 4000, 4000, -4000, -4000, -4000);
    send_edge(16'h7fff, 16'h7fff, 16'h8000, 0, 0, 0);
    set_view(16'(16384), 0, 16'(16384), 0, 1, 0, 0);
    send_edge(100, 100, 100, -100, -100, -100);
    send_edge(0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random;
    int             n;
    int             k;
    logic [15:0]    w;
    logic [9:0]     a, b;
    for (n = 0; n < 1620; n += k) begin
      w = $urandom_range(3) == 0 ? 16'($urandom_range(2047)) : 16'($urandom_range(1024, 256));
      a = $urandom_range(1023);
      b = $urandom_range(1023);
      if ($urandom_range(3) != 0 && a > b) {a, b} = {b, a};
      if (n / 60 % 6 == 5) w = 1024;
      set_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(), w, 16'(a), 16'(b));
      calm = (n >= 700 && n < 900);
      for (k = 0; k < 60; k++) begin
        send_edge(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    first_x_i  = '0; first_y_i  = '0; first_z_i  = '0;
    second_x_i = '0; second_y_i = '0; second_z_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = wepc_pkg::CFG_COS_YAW;
    cfg_data_i = '0;
    n_errors = 0; n_edges = 0; n_visible = 0; n_cfg = 0; cycle_cnt = 0; calm = 1'b0;
    m_cos_yaw = 16384; m_sin_yaw = 0; m_cos_pitch = 16384; m_sin_pitch = 0;
    m_width = 1024; m_top = 0; m_bot = 1023;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain();
    $display("projected %0d edges (%0d drawn) over %0d register writes",
             n_edges, n_visible, n_cfg);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
